FILE: hw/rtl/scf_pkg.sv
// Shared types, constants and rounding helper for the stereo crossfeed filter.
// No dependencies; every other file in hw/rtl uses this package.
package scf_pkg;

  localparam int SampleW = 24;
  localparam int FracBits = 20;
  localparam int ProdW = 2 * SampleW;
  localparam int AccW = ProdW + 2;
  localparam int MixW = SampleW + 1;
  localparam int MixProdW = MixW + SampleW;
  localparam int NumRegs = 6;
  localparam int CfgIdxW = $clog2(NumRegs);
  localparam int NumTaps = 5;
  localparam int CntW = $clog2(NumTaps + 1);

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [AccW-1:0] acc_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LO_FEED   = 3'd0,
    REG_LO_POLE   = 3'd1,
    REG_HI_FEED   = 3'd2,
    REG_HI_PREV   = 3'd3,
    REG_HI_POLE   = 3'd4,
    REG_OUT_GAIN  = 3'd5
  } cfg_reg_e;

  typedef enum logic [CntW-1:0] {
    TAP_LO_X    = 3'd0,
    TAP_LO_FB   = 3'd1,
    TAP_HI_X    = 3'd2,
    TAP_HI_PREV = 3'd3,
    TAP_HI_FB   = 3'd4
  } tap_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_COMMIT,
    S_MIX,
    S_DONE
  } state_e;

  typedef struct packed {
    sample_t lo_feed;
    sample_t lo_pole;
    sample_t hi_feed;
    sample_t hi_prev;
    sample_t hi_pole;
  } filt_coef_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    tap_e tap;
    logic commit;
  } lane_ctl_t;

  typedef struct packed {
    sample_t lo;
    sample_t hi;
  } lane_res_t;

  // floor((acc + 2^19) / 2^20), clamped to signed 24 bits
  function automatic sample_t round_sat(input acc_t acc);
    localparam int QW = AccW + 1 - FracBits;
    localparam logic signed [AccW:0] Half = (AccW + 1)'(1) << (FracBits - 1);
    localparam logic signed [QW-1:0] QMax = QW'((1 << (SampleW - 1)) - 1);
    localparam logic signed [QW-1:0] QMin = -QW'(1 << (SampleW - 1));
    logic signed [AccW:0] t;
    logic signed [QW-1:0] q;
    sample_t r;
    t = $signed({acc[AccW-1], acc}) + Half;
    q = t[AccW:FracBits];
    if (q > QMax) begin
      r = QMax[SampleW-1:0];
    end else if (q < QMin) begin
      r = QMin[SampleW-1:0];
    end else begin
      r = q[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/scf_in_if.sv
// Input channel of the crossfeed filter: one stereo frame per item.
// Depends on scf_pkg for the sample type.
interface scf_in_if;
  logic valid;
  logic ready;
  scf_pkg::sample_t left_in;
  scf_pkg::sample_t right_in;
  logic frame_last;

  modport source (output valid, output left_in, output right_in, output frame_last,
                  input ready);
  modport sink (input valid, input left_in, input right_in, input frame_last,
                output ready);
endinterface

FILE: hw/rtl/scf_out_if.sv
// Output channel of the crossfeed filter: one crossfed frame per item.
// Depends on scf_pkg for the sample type.
interface scf_out_if;
  logic valid;
  logic ready;
  scf_pkg::sample_t left_out;
  scf_pkg::sample_t right_out;
  logic out_last;

  modport source (output valid, output left_out, output right_out, output out_last,
                  input ready);
  modport sink (input valid, input left_out, input right_out, input out_last,
                output ready);
endinterface

FILE: hw/rtl/scf_cfg_if.sv
// Register write channel of the crossfeed filter: index and data per write.
// Depends on scf_pkg for the index and sample widths.
interface scf_cfg_if;
  logic valid;
  logic ready;
  logic [scf_pkg::CfgIdxW-1:0] index;
  scf_pkg::sample_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/scf_lane.sv
// One channel lane: low-pass and high-shelf filters on a shared 24x24 multiplier,
// one product per cycle, plus the lane's filter history. Depends on scf_pkg.
module scf_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scf_pkg::lane_ctl_t    ctl_i,
  input  scf_pkg::filt_coef_t   coef_i,
  input  scf_pkg::sample_t      x_i,
  output scf_pkg::lane_res_t    res_o
);
  import scf_pkg::*;

  sample_t x_q;
  sample_t lo_hist_q, hi_hist_q, prev_q;
  sample_t op_a, op_b;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic prod_lo_q, prod_vld_q;
  acc_t lo_acc_q, hi_acc_q;

  always_comb begin
    unique case (ctl_i.tap)
      TAP_LO_X: begin
        op_a = coef_i.lo_feed;
        op_b = x_q;
      end
      TAP_LO_FB: begin
        op_a = coef_i.lo_pole;
        op_b = lo_hist_q;
      end
      TAP_HI_X: begin
        op_a = coef_i.hi_feed;
        op_b = x_q;
      end
      TAP_HI_PREV: begin
        op_a = coef_i.hi_prev;
        op_b = prev_q;
      end
      TAP_HI_FB: begin
        op_a = coef_i.hi_pole;
        op_b = hi_hist_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      x_q <= x_i;
    end
    prod_q <= prod_d;
    prod_lo_q <= (ctl_i.tap == TAP_LO_X) || (ctl_i.tap == TAP_LO_FB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      lo_acc_q <= '0;
      hi_acc_q <= '0;
    end else if (ctl_i.load) begin
      prod_vld_q <= 1'b0;
      lo_acc_q <= '0;
      hi_acc_q <= '0;
    end else begin
      prod_vld_q <= ctl_i.mul_en;
      // fold in the product registered last cycle
      if (prod_vld_q) begin
        if (prod_lo_q) begin
          lo_acc_q <= lo_acc_q + AccW'(prod_q);
        end else begin
          hi_acc_q <= hi_acc_q + AccW'(prod_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_hist_q <= '0;
      hi_hist_q <= '0;
      prev_q <= '0;
    end else if (ctl_i.commit) begin
      lo_hist_q <= round_sat(lo_acc_q);
      hi_hist_q <= round_sat(hi_acc_q);
      prev_q <= x_q;
    end
  end

  assign res_o.lo = lo_hist_q;
  assign res_o.hi = hi_hist_q;

endmodule

FILE: hw/rtl/scf_merge.sv
// Merge stage: crosses the lanes (own shelf plus other low-pass), applies the
// output gain and rounds. Depends on scf_pkg.
module scf_merge (
  input  logic                 clk_i,
  input  logic                 mul_en_i,
  input  scf_pkg::lane_res_t   left_i,
  input  scf_pkg::lane_res_t   right_i,
  input  scf_pkg::sample_t     gain_i,
  output scf_pkg::sample_t     left_o,
  output scf_pkg::sample_t     right_o
);
  import scf_pkg::*;

  logic signed [MixW-1:0] sum_l, sum_r;
  logic signed [MixProdW-1:0] prod_l_q, prod_r_q;

  assign sum_l = MixW'(left_i.hi) + MixW'(right_i.lo);
  assign sum_r = MixW'(right_i.hi) + MixW'(left_i.lo);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_l_q <= sum_l * MixProdW'(gain_i);
      prod_r_q <= sum_r * MixProdW'(gain_i);
    end
  end

  assign left_o = round_sat(AccW'(prod_l_q));
  assign right_o = round_sat(AccW'(prod_r_q));

endmodule

FILE: hw/rtl/stereo_crossfeed_filter.sv
// Stereo headphone crossfeed: two filter lanes and a merge stage under one sequencer.
// Depends on scf_pkg, scf_in_if, scf_out_if, scf_cfg_if, scf_lane, scf_merge.
//
//   port   | dir | payload                          | handshake
//   in_i   | in  | left_in, right_in, frame_last    | valid/ready
//   out_o  | out | left_out, right_out, out_last    | valid/ready
//   cfg_i  | in  | index, data (6 coef registers)   | valid/ready, always ready
//
// After acceptance a frame passes through S_CALC for the five products per lane on the
// lane's single multiplier, S_COMMIT to round and store filter state, S_MIX for the
// gain multiply and S_DONE to round into the output register.
// One frame is in flight at a time; the next is taken once the result is registered,
// so a new frame is not accepted before the last one is through.
// A stalled output holds the block in its last step. Reset clears the
// coefficients and all filter history to zero; no clearing pass is needed.
module stereo_crossfeed_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  scf_in_if.sink     in_i,
  scf_out_if.source  out_o,
  scf_cfg_if.sink    cfg_i
);
  import scf_pkg::*;

  localparam logic [CntW-1:0] LastCnt = CntW'(NumTaps);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  filt_coef_t coef_q;
  sample_t gain_q;
  logic last_q;
  logic out_vld_q;
  sample_t out_l_q, out_r_q;
  logic out_last_q;
  logic in_acc, out_load;
  lane_ctl_t lane_ctl;
  lane_res_t res_l, res_r;
  sample_t mix_l, mix_r;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      gain_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LO_FEED:  coef_q.lo_feed <= cfg_i.data;
        REG_LO_POLE:  coef_q.lo_pole <= cfg_i.data;
        REG_HI_FEED:  coef_q.hi_feed <= cfg_i.data;
        REG_HI_PREV:  coef_q.hi_prev <= cfg_i.data;
        REG_HI_POLE:  coef_q.hi_pole <= cfg_i.data;
        REG_OUT_GAIN: gain_q <= cfg_i.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // sequencer
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc = in_i.valid && in_i.ready;
  assign out_load = (state_q == S_DONE) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CALC;
          cnt_d = '0;
        end
      end
      S_CALC: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastCnt) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: state_d = S_MIX;
      S_MIX:    state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    lane_ctl.load = in_acc;
    lane_ctl.mul_en = (state_q == S_CALC) && (cnt_q < LastCnt);
    lane_ctl.tap = tap_e'(cnt_q);
    lane_ctl.commit = (state_q == S_COMMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q <= in_i.frame_last;
    end
  end

  scf_lane u_lane_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .coef_i (coef_q),
    .x_i    (in_i.left_in),
    .res_o  (res_l)
  );

  scf_lane u_lane_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .coef_i (coef_q),
    .x_i    (in_i.right_in),
    .res_o  (res_r)
  );

  scf_merge u_merge (
    .clk_i    (clk_i),
    .mul_en_i (state_q == S_MIX),
    .left_i   (res_l),
    .right_i  (res_r),
    .gain_i   (gain_q),
    .left_o   (mix_l),
    .right_o  (mix_r)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_l_q <= mix_l;
      out_r_q <= mix_r;
      out_last_q <= last_q;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.left_out = out_l_q;
  assign out_o.right_out = out_r_q;
  assign out_o.out_last = out_last_q;

  // checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_CALC) && (cnt_q == '0))
    else $error("accepted item did not start the product sequence");

  a_commit_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> $past((state_q == S_CALC) && (cnt_q == LastCnt)))
    else $error("filter state stored before all products were summed");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("result shown without a finished item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> $stable(out_l_q) && $stable(out_r_q))
    else $error("pending result overwritten");

endmodule
